>>> rtl/circle_octant_rasterizer_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the circle octant rasterizer
// Implication checks sampled on the rising clock edge, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef CIRCLE_OCTANT_RASTERIZER_TOP_MACROS_SVH
`define CIRCLE_OCTANT_RASTERIZER_TOP_MACROS_SVH
`ifndef SYNTH
`define COR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: assertion failed");
`define COR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");
`else
`define COR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define COR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/cor_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cor_pkg
// Shared constants, codes and types of the circle octant rasterizer.
// ---------------------------------------------------------------------------
package cor_pkg;

	localparam int COORD_WIDTH_DEF  = 10;
	localparam int RADIUS_WIDTH_DEF = 9;

	localparam int PITCH_WIDTH     = 8;
	localparam int LINES_WIDTH     = 10;
	localparam int COL_WIDTH       = PITCH_WIDTH + 3;
	localparam int CFG_DATA_WIDTH  = 10;
	localparam int CFG_INDEX_WIDTH = 1;

	localparam logic [PITCH_WIDTH-1:0] PITCH_RESET = 8'd80;
	localparam logic [LINES_WIDTH-1:0] LINES_RESET = 10'd480;

	localparam int COLOR_WIDTH     = 4;
	localparam int DOT_WIDTH       = 12;
	localparam int OFFSET_WIDTH    = 16;
	localparam int MASK_WIDTH      = 8;
	localparam int DOT_INDEX_WIDTH = 3;

	localparam logic [MASK_WIDTH-1:0]      MASK_MSB = 8'h80;
	localparam logic [DOT_INDEX_WIDTH-1:0] DOT_LAST = 3'd7;

	localparam int STEP_QUEUE_DEPTH = 2;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_BYTES_PER_LINE = 1'b0,
		REG_VISIBLE_LINES  = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		FUNC_START = 1'b0,
		FUNC_STEP  = 1'b1
	} func_t;

	typedef enum logic [2:0] {
		FS_IDLE,
		FS_MUL,
		FS_DIFF,
		FS_ROOT,
		FS_PUSH
	} front_state_t;

endpackage

>>> rtl/circle_octant_rasterizer_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// circle_octant_rasterizer_top
// Eight-way symmetric circle rasterizer: one arc step per item, eight dots
// per step with planar byte offset, bit mask and colour.
// ---------------------------------------------------------------------------
//  channel   handshake          beat contents
//  input     push / full        func, center_x, center_y, radius, color
//  result    pop / empty        dot_x, dot_y, on_screen, byte_offset,
//                               bit_mask, dot_color, last_of_step, circle_done
//  config    cfg_we             cfg_index, cfg_data
//
//  After a step item is taken, full stays high through the squares, the
//  difference, the root bit by bit and the queueing of the step; no new
//  item is taken until the step is queued.
//  A full step queue holds the front; the dot side drains a step while
//  results are popped, overlapping the next root. An idle advance is dropped.
//  Reset is asynchronous; no clearing pass follows it.
// ---------------------------------------------------------------------------
module circle_octant_rasterizer_top #(
	parameter int COORD_WIDTH  = cor_pkg::COORD_WIDTH_DEF,
	parameter int RADIUS_WIDTH = cor_pkg::RADIUS_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic func,
	input  logic [COORD_WIDTH-1:0]  center_x,
	input  logic [COORD_WIDTH-1:0]  center_y,
	input  logic [RADIUS_WIDTH-1:0] radius,
	input  logic [cor_pkg::COLOR_WIDTH-1:0] color,
	output logic empty,
	input  logic pop,
	output logic signed [cor_pkg::DOT_WIDTH-1:0] dot_x,
	output logic signed [cor_pkg::DOT_WIDTH-1:0] dot_y,
	output logic on_screen,
	output logic [cor_pkg::OFFSET_WIDTH-1:0] byte_offset,
	output logic [cor_pkg::MASK_WIDTH-1:0]   bit_mask,
	output logic [cor_pkg::COLOR_WIDTH-1:0]  dot_color,
	output logic last_of_step,
	output logic circle_done,
	input  logic cfg_we,
	input  logic [cor_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [cor_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

	localparam int STEP_WIDTH = 2 * COORD_WIDTH + 2 * RADIUS_WIDTH + cor_pkg::COLOR_WIDTH + 1;

	logic [cor_pkg::PITCH_WIDTH-1:0] bytes_per_line_q;
	logic [cor_pkg::LINES_WIDTH-1:0] visible_lines_q;

	logic                  sq_push, sq_full, sq_valid, sq_pop;
	logic [STEP_WIDTH-1:0] sq_wr_data, sq_rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_per_line_q <= cor_pkg::PITCH_RESET;
			visible_lines_q  <= cor_pkg::LINES_RESET;
		end else if (cfg_we) begin
			unique case (cor_pkg::cfg_reg_t'(cfg_index))
				cor_pkg::REG_BYTES_PER_LINE:
					bytes_per_line_q <= cfg_data[cor_pkg::PITCH_WIDTH-1:0];
				cor_pkg::REG_VISIBLE_LINES:
					visible_lines_q <= cfg_data[cor_pkg::LINES_WIDTH-1:0];
			endcase
		end
	end

	cor_front #(
		.COORD_WIDTH  (COORD_WIDTH),
		.RADIUS_WIDTH (RADIUS_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.func      (func),
		.center_x  (center_x),
		.center_y  (center_y),
		.radius    (radius),
		.color     (color),
		.step_push (sq_push),
		.step_full (sq_full),
		.step_data (sq_wr_data)
	);

	cor_step_queue #(
		.WIDTH (STEP_WIDTH),
		.DEPTH (cor_pkg::STEP_QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (sq_push),
		.full    (sq_full),
		.wr_data (sq_wr_data),
		.valid   (sq_valid),
		.pop     (sq_pop),
		.rd_data (sq_rd_data)
	);

	cor_back #(
		.COORD_WIDTH  (COORD_WIDTH),
		.RADIUS_WIDTH (RADIUS_WIDTH)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.step_valid     (sq_valid),
		.step_pop       (sq_pop),
		.step_data      (sq_rd_data),
		.bytes_per_line (bytes_per_line_q),
		.visible_lines  (visible_lines_q),
		.empty          (empty),
		.pop            (pop),
		.dot_x          (dot_x),
		.dot_y          (dot_y),
		.on_screen      (on_screen),
		.byte_offset    (byte_offset),
		.bit_mask       (bit_mask),
		.dot_color      (dot_color),
		.last_of_step   (last_of_step),
		.circle_done    (circle_done)
	);

endmodule

>>> rtl/cor_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cor_front
// Accepts items, keeps the circle state and works out the next minor axis
// with a digit-by-digit square root, then queues one step descriptor.
// ---------------------------------------------------------------------------
`include "circle_octant_rasterizer_top_macros.svh"

module cor_front #(
	parameter int COORD_WIDTH  = cor_pkg::COORD_WIDTH_DEF,
	parameter int RADIUS_WIDTH = cor_pkg::RADIUS_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic                     func,
	input  logic [COORD_WIDTH-1:0]   center_x,
	input  logic [COORD_WIDTH-1:0]   center_y,
	input  logic [RADIUS_WIDTH-1:0]  radius,
	input  logic [cor_pkg::COLOR_WIDTH-1:0] color,
	output logic                     step_push,
	input  logic                     step_full,
	output logic [2*COORD_WIDTH+2*RADIUS_WIDTH+cor_pkg::COLOR_WIDTH:0] step_data
);

	localparam int SQ_WIDTH    = 2 * RADIUS_WIDTH;
	localparam int RAD_WIDTH   = SQ_WIDTH + 2;
	localparam int ROOT_WIDTH  = RADIUS_WIDTH + 1;
	localparam int REM_WIDTH   = RADIUS_WIDTH + 2;
	localparam int TRIAL_WIDTH = REM_WIDTH + 2;
	localparam int ITER_WIDTH  = $clog2(ROOT_WIDTH);
	localparam logic [ITER_WIDTH-1:0] ITER_LAST = ITER_WIDTH'(ROOT_WIDTH - 1);

	cor_pkg::front_state_t state_q, state_d;
	logic active_q;

	logic [COORD_WIDTH-1:0]  cx_q, cy_q;
	logic [RADIUS_WIDTH-1:0] r_q, major_q, minor_q;
	logic [cor_pkg::COLOR_WIDTH-1:0] color_q;
	logic [SQ_WIDTH-1:0]     rr_q, aa_q;
	logic [RAD_WIDTH-1:0]    rad_q;
	logic [REM_WIDTH-1:0]    rem_q;
	logic [ROOT_WIDTH-1:0]   root_q;
	logic [ITER_WIDTH-1:0]   iter_q;

	logic                    accept;
	logic                    start;
	logic [RADIUS_WIDTH-1:0] na;
	logic [TRIAL_WIDTH-1:0]  rem_sh, trial, rem_sub;
	logic                    fits;
	logic [ROOT_WIDTH:0]     root_inc;
	logic [ROOT_WIDTH-1:0]   nb_full;
	logic                    step_done;

	assign accept = push && !full;
	assign start  = (func == cor_pkg::FUNC_START);
	assign na     = RADIUS_WIDTH'(major_q + 1'b1);

	// one root bit per cycle: bring down two radicand bits, try 4*root+1
	assign rem_sh  = {rem_q, rad_q[RAD_WIDTH-1 -: 2]};
	assign trial   = {{(TRIAL_WIDTH-ROOT_WIDTH-2){1'b0}}, root_q, 2'b01};
	assign fits    = (rem_sh >= trial);
	assign rem_sub = rem_sh - trial;

	// root_q is floor(sqrt(4N)); the rounded root is root_q plus one, halved
	assign root_inc  = {1'b0, root_q} + 1'b1;
	assign nb_full   = root_inc[ROOT_WIDTH:1];
	assign step_done = ({1'b0, na} > nb_full);

	assign step_data = {cx_q, cy_q, major_q, minor_q, color_q, step_done};

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cor_pkg::FS_IDLE: begin
				if (accept && (start || active_q)) begin
					state_d = cor_pkg::FS_MUL;
				end
			end
			cor_pkg::FS_MUL:  state_d = cor_pkg::FS_DIFF;
			cor_pkg::FS_DIFF: state_d = cor_pkg::FS_ROOT;
			cor_pkg::FS_ROOT: begin
				if (iter_q == ITER_LAST) begin
					state_d = cor_pkg::FS_PUSH;
				end
			end
			cor_pkg::FS_PUSH: begin
				if (!step_full) begin
					state_d = cor_pkg::FS_IDLE;
				end
			end
			default: state_d = cor_pkg::FS_IDLE;
		endcase
	end

	always_comb begin
		full      = (state_q != cor_pkg::FS_IDLE);
		step_push = (state_q == cor_pkg::FS_PUSH) && !step_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= cor_pkg::FS_IDLE;
			active_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && start) begin
				active_q <= 1'b1;
			end else if (step_push && step_done) begin
				active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && start) begin
			cx_q    <= center_x;
			cy_q    <= center_y;
			r_q     <= radius;
			color_q <= color;
			major_q <= '0;
			minor_q <= radius;
		end
		if (state_q == cor_pkg::FS_MUL) begin
			rr_q <= SQ_WIDTH'(r_q) * SQ_WIDTH'(r_q);
			aa_q <= SQ_WIDTH'(na) * SQ_WIDTH'(na);
		end
		if (state_q == cor_pkg::FS_DIFF) begin
			// clamp a negative radicand to zero
			rad_q  <= (rr_q > aa_q) ? {rr_q - aa_q, 2'b00} : '0;
			rem_q  <= '0;
			root_q <= '0;
			iter_q <= '0;
		end
		if (state_q == cor_pkg::FS_ROOT) begin
			rad_q  <= {rad_q[RAD_WIDTH-3:0], 2'b00};
			rem_q  <= fits ? rem_sub[REM_WIDTH-1:0] : rem_sh[REM_WIDTH-1:0];
			root_q <= {root_q[ROOT_WIDTH-2:0], fits};
			iter_q <= iter_q + 1'b1;
		end
		if (step_push) begin
			major_q <= na;
			minor_q <= nb_full[RADIUS_WIDTH-1:0];
		end
	end

	`COR_ASSERT_NEXT(a_root_starts_clean, clk, arst_n, state_q == cor_pkg::FS_DIFF, state_q == cor_pkg::FS_ROOT && iter_q == '0)
	`COR_ASSERT_NEXT(a_done_ends_circle, clk, arst_n, step_push && step_done, !active_q)

endmodule

>>> rtl/cor_step_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cor_step_queue
// Short first-in first-out queue of step descriptors between the halves.
// ---------------------------------------------------------------------------
`include "circle_octant_rasterizer_top_macros.svh"

module cor_step_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = cor_pkg::STEP_QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  logic [WIDTH-1:0] wr_data,
	output logic             valid,
	input  logic             pop,
	output logic [WIDTH-1:0] rd_data
);

	localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_WIDTH = $clog2(DEPTH + 1);
	localparam logic [PTR_WIDTH-1:0] PTR_LAST = PTR_WIDTH'(DEPTH - 1);
	localparam logic [CNT_WIDTH-1:0] CNT_FULL = CNT_WIDTH'(DEPTH);

	logic [WIDTH-1:0]     entry_q [DEPTH];
	logic [PTR_WIDTH-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_WIDTH-1:0] count_q;
	logic                 do_push, do_pop;

	assign full    = (count_q == CNT_FULL);
	assign valid   = (count_q != '0);
	assign do_push = push && !full;
	assign do_pop  = pop && valid;
	assign rd_data = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

	`COR_ASSERT_IMP(a_count_bounded, clk, arst_n, 1'b1, count_q <= CNT_FULL)

endmodule

>>> rtl/cor_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cor_back
// Expands one step descriptor into its eight symmetric dots, with display address
// and bit mask, into the result register, one a cycle while it is free or popped.
// ---------------------------------------------------------------------------
`include "circle_octant_rasterizer_top_macros.svh"

module cor_back #(
	parameter int COORD_WIDTH  = cor_pkg::COORD_WIDTH_DEF,
	parameter int RADIUS_WIDTH = cor_pkg::RADIUS_WIDTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic step_valid,
	output logic step_pop,
	input  logic [2*COORD_WIDTH+2*RADIUS_WIDTH+cor_pkg::COLOR_WIDTH:0] step_data,
	input  logic [cor_pkg::PITCH_WIDTH-1:0] bytes_per_line,
	input  logic [cor_pkg::LINES_WIDTH-1:0] visible_lines,
	output logic empty,
	input  logic pop,
	output logic signed [cor_pkg::DOT_WIDTH-1:0] dot_x,
	output logic signed [cor_pkg::DOT_WIDTH-1:0] dot_y,
	output logic on_screen,
	output logic [cor_pkg::OFFSET_WIDTH-1:0] byte_offset,
	output logic [cor_pkg::MASK_WIDTH-1:0]   bit_mask,
	output logic [cor_pkg::COLOR_WIDTH-1:0]  dot_color,
	output logic last_of_step,
	output logic circle_done
);

	localparam int EXT_WIDTH = ((COORD_WIDTH > RADIUS_WIDTH) ? COORD_WIDTH : RADIUS_WIDTH) + 2;
	localparam int CMP_WIDTH = EXT_WIDTH + cor_pkg::COL_WIDTH;
	localparam int SGN_WIDTH = EXT_WIDTH + cor_pkg::DOT_WIDTH;
	localparam int PROD_WIDTH = cor_pkg::LINES_WIDTH + cor_pkg::PITCH_WIDTH;

	logic [COORD_WIDTH-1:0]  cx, cy;
	logic [RADIUS_WIDTH-1:0] a, b, u, v;
	logic [cor_pkg::COLOR_WIDTH-1:0] col;
	logic                    done;

	logic [cor_pkg::DOT_INDEX_WIDTH-1:0] k_q;
	logic                    out_valid_q;
	logic                    load;

	logic [EXT_WIDTH-1:0]    cx_e, cy_e, u_e, v_e, x, y;
	logic [CMP_WIDTH-1:0]    x_z, y_z;
	logic [SGN_WIDTH-1:0]    x_s, y_s;
	logic [cor_pkg::COL_WIDTH-1:0] cols;
	logic                    on;
	logic [PROD_WIDTH-1:0]   prod;
	logic [cor_pkg::OFFSET_WIDTH-1:0] offset;
	logic [cor_pkg::MASK_WIDTH-1:0]   mask;

	assign {cx, cy, a, b, col, done} = step_data;

	// dot k: bit 2 swaps the axes, bit 0 mirrors x, bit 1 picks the lower half
	assign u    = k_q[2] ? b : a;
	assign v    = k_q[2] ? a : b;
	assign cx_e = EXT_WIDTH'(cx);
	assign cy_e = EXT_WIDTH'(cy);
	assign u_e  = EXT_WIDTH'(u);
	assign v_e  = EXT_WIDTH'(v);
	assign x    = k_q[0] ? cx_e - u_e : cx_e + u_e;
	assign y    = k_q[1] ? cy_e + v_e : cy_e - v_e;

	assign x_z  = {{cor_pkg::COL_WIDTH{1'b0}}, x};
	assign y_z  = {{cor_pkg::COL_WIDTH{1'b0}}, y};
	assign x_s  = {{cor_pkg::DOT_WIDTH{x[EXT_WIDTH-1]}}, x};
	assign y_s  = {{cor_pkg::DOT_WIDTH{y[EXT_WIDTH-1]}}, y};
	assign cols = {bytes_per_line, 3'b000};

	assign on = !x[EXT_WIDTH-1] && !y[EXT_WIDTH-1]
		&& (x_z < CMP_WIDTH'(cols)) && (y_z < CMP_WIDTH'(visible_lines));

	assign prod   = y_z[cor_pkg::LINES_WIDTH-1:0] * PROD_WIDTH'(bytes_per_line);
	assign offset = prod[cor_pkg::OFFSET_WIDTH-1:0]
		+ cor_pkg::OFFSET_WIDTH'(x_z[cor_pkg::COL_WIDTH-1:3]);
	assign mask   = cor_pkg::MASK_MSB >> x_z[2:0];

	assign load     = step_valid && (!out_valid_q || pop);
	assign step_pop = load && (k_q == cor_pkg::DOT_LAST);
	assign empty    = !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				k_q         <= k_q + 1'b1;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dot_x        <= x_s[cor_pkg::DOT_WIDTH-1:0];
			dot_y        <= y_s[cor_pkg::DOT_WIDTH-1:0];
			on_screen    <= on;
			// zero address and mask off screen
			byte_offset  <= on ? offset : '0;
			bit_mask     <= on ? mask : '0;
			dot_color    <= col;
			last_of_step <= (k_q == cor_pkg::DOT_LAST);
			circle_done  <= done;
		end
	end

	`COR_ASSERT_IMP(a_step_held_mid_way, clk, arst_n, k_q != '0, step_valid)

endmodule
